### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Invariant that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("%m: assertion failed");

`endif

### sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants, types and functions of the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int IN_FRAC   = 28;
    localparam int C_W       = 32;
    localparam int Z_W       = FRAC_BITS + 8;
    localparam int SQ_W      = FRAC_BITS + 10;
    localparam int PROD_W    = 2 * Z_W;
    localparam int CNT_W     = 17;
    localparam int KEY_W     = 11;
    localparam int KEYP_W    = SQ_W + KEY_W;
    localparam int KEYQ_W    = KEYP_W - FRAC_BITS;
    localparam int VAL_W     = KEYQ_W + 1;
    localparam int RES_W     = 20;
    localparam int TDATA_IN_W  = 2 * C_W;
    localparam int TDATA_OUT_W = 24;
    localparam int C_SHL     = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
    localparam int C_SHR     = (FRAC_BITS < IN_FRAC) ? (IN_FRAC - FRAC_BITS) : 0;
    localparam int CW_W      = C_W + C_SHL;

    localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100000);
    localparam logic [KEY_W-1:0] KEY_MUL        = KEY_W'(2003);
    localparam logic [SQ_W-1:0]  FOUR           = SQ_W'(4) << FRAC_BITS;
    localparam logic [RES_W-1:0] RESULT_MAX     = {RES_W{1'b1}};

    typedef enum logic {
        OP_KEYED = 1'b0,
        OP_COUNT = 1'b1
    } op_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic key;
        logic finish;
    } mbe_cmd_t;

    typedef struct packed {
        logic cont;
        logic out_free;
    } mbe_status_t;

    function automatic logic signed [Z_W-1:0] align_c(input logic signed [C_W-1:0] c);
        logic signed [CW_W-1:0] w;
        w = CW_W'(c);
        w = w <<< C_SHL;
        w = w >>> C_SHR;
        return Z_W'(w);
    endfunction

endpackage

### sv/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer that steps the datapath through the iterations of one point.
// ----------------------------------------------------------------------------
module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  mbe_status_t status,
    output mbe_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_TEST = 5'b00100,
        ST_KEY  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (status.cont) begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY: begin
                cmd.key    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/mbe_datapath.sv
// ----------------------------------------------------------------------------
// mbe_datapath
// Point registers, square and cross products, update, key and result stage.
// ----------------------------------------------------------------------------
module mbe_datapath
    import mbe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata,
    input  mbe_cmd_t               cmd,
    output mbe_status_t            status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    logic [CNT_W-1:0]        max_iter_reg;
    logic signed [Z_W-1:0]   cr_reg;
    logic signed [Z_W-1:0]   ci_reg;
    op_t                     op_reg;
    logic signed [Z_W-1:0]   x_reg;
    logic signed [Z_W-1:0]   y_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SQ_W-1:0]         xx_reg;
    logic [SQ_W-1:0]         yy_reg;
    logic signed [Z_W-1:0]   xy2_reg;
    logic [KEYP_W-1:0]       keyp_reg;
    logic [RES_W-1:0]        result_reg;
    logic                    valid_reg;

    logic signed [PROD_W-1:0] p_xx;
    logic signed [PROD_W-1:0] p_yy;
    logic signed [PROD_W-1:0] p_xy;
    logic [SQ_W-1:0]          sum_sq;
    logic [SQ_W-1:0]          cr_ext;
    logic [SQ_W-1:0]          x_new;
    logic [VAL_W-1:0]         key_val;
    logic [VAL_W-1:0]         val;
    logic [RES_W-1:0]         result_next;
    logic                     valid_next;

    assign p_xx   = PROD_W'(x_reg) * PROD_W'(x_reg);
    assign p_yy   = PROD_W'(y_reg) * PROD_W'(y_reg);
    assign p_xy   = PROD_W'(x_reg) * PROD_W'(y_reg);
    assign sum_sq = xx_reg + yy_reg;
    assign cr_ext = SQ_W'(cr_reg);
    assign x_new  = xx_reg - yy_reg + cr_ext;

    assign key_val = VAL_W'(keyp_reg[FRAC_BITS +: KEYQ_W]) + VAL_W'(count_reg);

    always_comb begin
        if (op_reg == OP_COUNT) begin
            val = VAL_W'(count_reg);
        end else begin
            val = key_val;
        end
        if (val > VAL_W'(RESULT_MAX)) begin
            result_next = RESULT_MAX;
        end else begin
            result_next = val[RES_W-1:0];
        end
    end

    assign status.cont     = (count_reg < max_iter_reg) && (sum_sq < FOUR);
    assign status.out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (cmd.finish) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_iter_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cr_reg    <= align_c(s_tdata[C_W-1:0]);
            ci_reg    <= align_c(s_tdata[2*C_W-1:C_W]);
            op_reg    <= op_t'(s_tuser);
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
        end
        if (cmd.mul) begin
            xx_reg  <= p_xx[FRAC_BITS +: SQ_W];
            yy_reg  <= p_yy[FRAC_BITS +: SQ_W];
            xy2_reg <= p_xy[FRAC_BITS-1 +: Z_W];
        end
        if (cmd.step) begin
            x_reg     <= x_new[Z_W-1:0];
            y_reg     <= xy2_reg + ci_reg;
            count_reg <= count_reg + CNT_W'(1);
        end
        if (cmd.key) begin
            keyp_reg <= KEYP_W'(sum_sq) * KEYP_W'(KEY_MUL);
        end
        if (cmd.finish) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_OUT_W'(result_reg);

endmodule

### sv/mandelbrot_escape_time_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Each iteration passes through the three parallel product multipliers and
// then the update adders; a new point is accepted only once the previous
// result has been handed to the output register.
// Reset: synchronous active-low aresetn clears control state and sets the
// iteration limit to 100000; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mandelbrot_escape_time_top
    import mbe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // c_real, c_imag
    input  logic                   s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // result_value, zero padding
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata
);

    mbe_cmd_t    cmd;
    mbe_status_t status;

    mbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ASSERT_ALWAYS(a_cmd_onehot, aclk, aresetn, $onehot0(cmd))
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.finish, !m_tvalid || m_tready)
    `ASSERT_IMPLIES(a_result_from_finish, aclk, aresetn, $rose(m_tvalid), $past(cmd.finish))

endmodule

### tb/tb_mandelbrot_escape_time_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time testbench
// Streams complex points into the block under several iteration limits and
// checks every result against a bit-accurate fixed-point predictor. The
// sender works in bursts and the receiver stalls on its own random pattern.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_top;
    import mbe_pkg::*;

    localparam logic signed [C_W-1:0] ONE   = 32'sh1000_0000;
    localparam logic signed [C_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [C_W-1:0] C_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [C_W-1:0] re;
        logic signed [C_W-1:0] im;
        op_t                   op;
    } point_t;

    class escape_scoreboard;
        logic [RES_W-1:0] expected_values[$];
        logic [CNT_W-1:0] iter_limit;
        int               errors;
        int               points_seen;
        int               inside_seen;

        function new();
            iter_limit  = MAX_ITER_RESET;
            errors      = 0;
            points_seen = 0;
            inside_seen = 0;
        endfunction

        function void set_limit(input logic [CNT_W-1:0] value);
            iter_limit = value;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function void note_point(input point_t p);
            logic signed [PROD_W-1:0] cr, ci, x, y, xx, yy, xy2, mag, four;
            logic [PROD_W-1:0]        scaled;
            int                       iters;

            four = PROD_W'(4) <<< FRAC_BITS;
            cr   = PROD_W'(p.re);
            ci   = PROD_W'(p.im);
            cr   = (cr <<< C_SHL) >>> C_SHR;
            ci   = (ci <<< C_SHL) >>> C_SHR;
            x     = '0;
            y     = '0;
            iters = 0;
            while (iters < int'(iter_limit)) begin
                xx = (x * x) >>> FRAC_BITS;
                yy = (y * y) >>> FRAC_BITS;
                if (xx + yy >= four) begin
                    break;
                end
                xy2 = (x * y) >>> (FRAC_BITS - 1);
                x   = xx - yy + cr;
                y   = xy2 + ci;
                iters++;
            end
            if (iters == int'(iter_limit)) begin
                inside_seen++;
            end
            xx  = (x * x) >>> FRAC_BITS;
            yy  = (y * y) >>> FRAC_BITS;
            mag = xx + yy;
            if (p.op == OP_COUNT) begin
                scaled = PROD_W'(iters);
            end else begin
                scaled = ((mag * PROD_W'(KEY_MUL)) >> FRAC_BITS) + PROD_W'(iters);
            end
            if (scaled > PROD_W'(RESULT_MAX)) begin
                scaled = PROD_W'(RESULT_MAX);
            end
            expected_values.push_back(scaled[RES_W-1:0]);
            points_seen++;
        endfunction

        function void check_result(input logic [RES_W-1:0] actual);
            logic [RES_W-1:0] want;

            if (expected_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
                errors++;
            end else begin
                want = expected_values.pop_front();
                if (actual !== want) begin
                    $display("%0t: result_value mismatch, expected %0d, actual %0d",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CNT_W-1:0]       cfg_wdata = '0;

    escape_scoreboard sb = new();
    int               limits_used = 1;
    int               stall_mode  = 0;
    int               stall_left  = 0;

    mandelbrot_escape_time_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver alternates between always ready, random and mostly stalled.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(2);
            stall_left <= $urandom_range(80, 8);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(1));
            end
            default: begin
                m_tready <= ($urandom_range(3) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[RES_W-1:0]);
        end
    end

    task automatic send_point(input point_t p);
        s_tdata  <= {p.im, p.re};
        s_tuser  <= p.op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_point(p);
    endtask

    task automatic send_points(input point_t pts[$]);
        int burst_left;
        int gap;

        burst_left = ($urandom_range(3) == 0) ? 20 : $urandom_range(6, 1);
        foreach (pts[i]) begin
            send_point(pts[i]);
            burst_left--;
            if (burst_left == 0) begin
                gap = $urandom_range(6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(3) == 0) ? 20 : $urandom_range(6, 1);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_limit(value);
        limits_used++;
    endtask

    function automatic point_t random_point();
        point_t p;

        case ($urandom_range(9))
            7: begin
                p.re = $urandom_range(268435455) - 32'd134217728;
                p.im = $urandom_range(268435455) - 32'd134217728;
            end
            8, 9: begin
                p.re = $urandom;
                p.im = $urandom;
            end
            default: begin
                p.re = $urandom_range(1073741823) - 32'd671088640;
                p.im = $urandom_range(805306367) - 32'd402653184;
            end
        endcase
        p.op = op_t'($urandom_range(1));
        return p;
    endfunction

    initial begin
        point_t batch[$];
        logic [CNT_W-1:0] lim;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset limit: one point that never escapes, the field extremes, then two points on the real axis.
        batch = '{
            '{32'sd0, 32'sd0, OP_KEYED},
            '{C_MIN, C_MIN, OP_COUNT},
            '{C_MAX, C_MAX, OP_KEYED},
            '{C_MAX, C_MIN, OP_COUNT},
            '{C_MIN, C_MAX, OP_KEYED},
            '{-(2 * ONE), 32'sd0, OP_COUNT},
            '{ONE / 4 + ONE / 64, 32'sd0, OP_KEYED}
        };
        send_points(batch);

        write_limit('0);
        batch = '{
            '{32'sd0, 32'sd0, OP_KEYED},
            '{C_MAX, C_MIN, OP_COUNT},
            '{C_MIN, C_MIN, OP_KEYED}
        };
        send_points(batch);

        write_limit(CNT_W'(1));
        batch = '{
            '{32'sd0, 32'sd0, OP_COUNT},
            '{C_MAX, C_MAX, OP_KEYED},
            '{ONE, ONE, OP_KEYED}
        };
        send_points(batch);

        write_limit('1);
        batch = '{
            '{32'sd0, 32'sd0, OP_COUNT},
            '{ONE / 4 + ONE / 64, ONE / 16, OP_KEYED}
        };
        send_points(batch);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: lim = CNT_W'($urandom_range(40, 2));
                1: lim = CNT_W'($urandom_range(300, 41));
                2: lim = CNT_W'($urandom_range(800, 301));
                3: lim = CNT_W'(1);
                default: lim = CNT_W'($urandom_range(20, 2));
            endcase
            write_limit(lim);
            batch.delete();
            repeat (20) batch.push_back(random_point());
            send_points(batch);
        end

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Checked %0d points under %0d iteration limits, %0d of them ran to the limit.",
                 sb.points_seen, limits_used, sb.inside_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
